FILE: rtl/frqkl_pkg.sv
// Shared types and constants for the frame ring queue with keep-last.
`timescale 1ns / 1ps

package frqkl_pkg;

    // Count, size and slot arithmetic width (active size never exceeds 31).
    localparam int CNT_W  = 5;
    localparam int DUR_W  = 16;
    localparam int SUM_W  = 20;
    localparam int SLOT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_NEXT  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SHOWN  = 2'd1;

endpackage

FILE: rtl/frame_ring_queue_keep_last.sv
// Frame ring queue with keep-last: slot index and duration bookkeeping.
`timescale 1ns / 1ps

// Channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// input     | in_valid / in_ready    | command, frame_dur, abort_request
// result    | out_valid / out_ready  | accepted, write_slot, show_slot, last_slot,
//           |                        | next_slot, remaining, total_duration,
//           |                        | full_res, empty_res, aborted
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data (0 max_entries, 1 hold shown)
//
// An item passes an input register and a result register, and a new item can transfer
// every cycle while results drain and no pointer reduction is under way.
// The limit is the state update loop: pointers, count and total feed back combinationally.
// Reset clears pointers, count, shown flag and total; slot durations are unset.
// After a max_entries write the pointers are reduced one subtraction a cycle once the
// next item sits in the input register, with in_ready low until they are in range.
// A stalled result holds the input register.
module frame_ring_queue_keep_last
    import frqkl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [DUR_W-1:0]      frame_dur,
    input  logic                  abort_request,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accepted,
    output logic [SLOT_W-1:0]     write_slot,
    output logic [SLOT_W-1:0]     show_slot,
    output logic [SLOT_W-1:0]     last_slot,
    output logic [SLOT_W-1:0]     next_slot,
    output logic [CNT_W-1:0]      remaining,
    output logic [SUM_W-1:0]      total_duration,
    output logic                  full_res,
    output logic                  empty_res,
    output logic                  aborted,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // max_entries is 5 bits, so no more than 31 slots are ever in use.
    localparam int SIZE_MAX   = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;
    localparam int IDX_W      = $clog2(SIZE_MAX);
    localparam int RESET_SIZE = (SIZE_MAX < 16) ? SIZE_MAX : 16;

    // ---------------------------------------------------------------
    // Configuration: active size kept already clamped to 1..SIZE_MAX
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] size_reg;
    logic             hold_shown_reg;
    logic             cfg_xfer;
    logic [CNT_W-1:0] cfg_size;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_size = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_size = CNT_W'(1);
        end
        else if (cfg_data > CNT_W'(SIZE_MAX))
        begin
            cfg_size = CNT_W'(SIZE_MAX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= CNT_W'(RESET_SIZE);
            hold_shown_reg <= 1'b0;
        end
        else if (cfg_xfer)
        begin
            if (cfg_index == CFG_MAX_ENTRIES)
            begin
                size_reg <= cfg_size;
            end
            else if (cfg_index == CFG_HOLD_SHOWN)
            begin
                hold_shown_reg <= cfg_data[0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic             in_vld_reg;
    cmd_t             cmd_reg;
    logic [DUR_W-1:0] dur_reg;
    logic             abort_reg;
    logic             in_xfer;
    logic             proc;
    logic             out_free;
    logic             reducing;

    assign out_free = !out_valid || out_ready;
    assign proc     = in_vld_reg && out_free && !reducing;
    assign in_ready = (!in_vld_reg || proc) && !reducing;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg   <= cmd_t'(command);
            dur_reg   <= frame_dur;
            abort_reg <= abort_request;
        end
    end

    // ---------------------------------------------------------------
    // Queue state
    // ---------------------------------------------------------------
    logic [IDX_W-1:0] w_reg, w_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             shown_reg, shown_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    // Duration memory, read ahead through a register at the next read pointer.
    logic [DUR_W-1:0] dur_mem [SIZE_MAX];
    logic [DUR_W-1:0] rd_data_reg;
    logic             byp_reg;
    logic [DUR_W-1:0] byp_data_reg;
    logic [DUR_W-1:0] head_dur;
    logic             push_do;

    assign head_dur = byp_reg ? byp_data_reg : rd_data_reg;

    logic [CNT_W-1:0] w5, r5, rem, rem_next, w_inc, r_inc;
    logic [CNT_W-1:0] show5, next5, show_inc;
    logic [SUM_W:0]   sum_add;
    logic             acc;

    assign w5 = CNT_W'(w_reg);
    assign r5 = CNT_W'(r_reg);
    // Pointers left beyond a shrunk ring are brought back into range once an item waits,
    // so a later resize before any item still works from the untouched pointers.
    assign reducing = in_vld_reg && ((w5 >= size_reg) || (r5 >= size_reg));

    always_comb
    begin
        w_next     = w_reg;
        r_next     = r_reg;
        count_next = count_reg;
        shown_next = shown_reg;
        sum_next   = sum_reg;
        push_do    = 1'b0;
        acc        = 1'b0;

        rem   = (count_reg > CNT_W'(shown_reg)) ? count_reg - CNT_W'(shown_reg) : '0;
        w_inc = ((w5 + 1'b1) == size_reg) ? '0 : w5 + 1'b1;
        r_inc = ((r5 + 1'b1) == size_reg) ? '0 : r5 + 1'b1;
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(dur_reg);

        if (reducing)
        begin
            if (w5 >= size_reg)
            begin
                w_next = IDX_W'(w5 - size_reg);
            end
            if (r5 >= size_reg)
            begin
                r_next = IDX_W'(r5 - size_reg);
            end
        end
        else if (proc)
        begin
            case (cmd_reg)
                CMD_PUSH:
                begin
                    if ((count_reg < size_reg) && !abort_reg)
                    begin
                        push_do    = 1'b1;
                        w_next     = IDX_W'(w_inc);
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                        acc        = 1'b1;
                    end
                end
                CMD_NEXT:
                begin
                    if (rem != '0)
                    begin
                        if (hold_shown_reg && !shown_reg)
                        begin
                            shown_next = 1'b1;
                        end
                        else
                        begin
                            r_next     = IDX_W'(r_inc);
                            count_next = count_reg - 1'b1;
                            sum_next   = (sum_reg > SUM_W'(head_dur))
                                       ? sum_reg - SUM_W'(head_dur) : '0;
                        end
                        acc = 1'b1;
                    end
                end
                CMD_QUERY:
                begin
                    acc = 1'b1;
                end
                default:
                begin
                    acc = 1'b0;
                end
            endcase
        end
    end

    // Result view of the updated state.
    always_comb
    begin
        rem_next = (count_next > CNT_W'(shown_next)) ? count_next - CNT_W'(shown_next) : '0;
        show5    = CNT_W'(r_next) + CNT_W'(shown_next);
        if (show5 >= size_reg)
        begin
            show5 = show5 - size_reg;
        end
        show_inc = show5 + 1'b1;
        next5    = (show_inc >= size_reg) ? show_inc - size_reg : show_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg     <= '0;
            r_reg     <= '0;
            count_reg <= '0;
            shown_reg <= 1'b0;
            sum_reg   <= '0;
        end
        else
        begin
            w_reg     <= w_next;
            r_reg     <= r_next;
            count_reg <= count_next;
            shown_reg <= shown_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_do)
        begin
            dur_mem[w_reg] <= dur_reg;
        end
        rd_data_reg  <= dur_mem[r_next];
        byp_reg      <= push_do && (w_reg == r_next);
        byp_data_reg <= dur_reg;
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    logic [CNT_W-1:0] wn5;
    logic [CNT_W-1:0] rn5;

    assign wn5 = CNT_W'(w_next);
    assign rn5 = CNT_W'(r_next);

    logic              acc_reg;
    logic [SLOT_W-1:0] wslot_reg, sslot_reg, lslot_reg, nslot_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  total_reg;
    logic              full_reg, empty_reg, aborted_reg;

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            acc_reg     <= acc;
            wslot_reg   <= wn5[SLOT_W-1:0];
            sslot_reg   <= show5[SLOT_W-1:0];
            lslot_reg   <= rn5[SLOT_W-1:0];
            nslot_reg   <= next5[SLOT_W-1:0];
            rem_reg     <= rem_next;
            total_reg   <= sum_next;
            full_reg    <= (count_next >= size_reg);
            empty_reg   <= (rem_next == '0);
            aborted_reg <= abort_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = acc_reg;
    assign write_slot     = wslot_reg;
    assign show_slot      = sslot_reg;
    assign last_slot      = lslot_reg;
    assign next_slot      = nslot_reg;
    assign remaining      = rem_reg;
    assign total_duration = total_reg;
    assign full_res       = full_reg;
    assign empty_res      = empty_reg;
    assign aborted        = aborted_reg;

endmodule

FILE: tb/ring_status_checker.sv
// Checker for the frame ring queue: watches all three channels, predicts each status, compares.
`timescale 1ns / 1ps

module ring_status_checker
    import frqkl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [DUR_W-1:0]      frame_dur,
    input  logic                  abort_request,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  accepted,
    input  logic [SLOT_W-1:0]     write_slot,
    input  logic [SLOT_W-1:0]     show_slot,
    input  logic [SLOT_W-1:0]     last_slot,
    input  logic [SLOT_W-1:0]     next_slot,
    input  logic [CNT_W-1:0]      remaining,
    input  logic [SUM_W-1:0]      total_duration,
    input  logic                  full_res,
    input  logic                  empty_res,
    input  logic                  aborted,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    mismatches,
    output int                    outstanding
);

    typedef struct {
        logic              acc;
        logic [SLOT_W-1:0] wr_slot;
        logic [SLOT_W-1:0] show;
        logic [SLOT_W-1:0] last;
        logic [SLOT_W-1:0] nxt;
        logic [CNT_W-1:0]  rem;
        logic [SUM_W-1:0]  total;
        logic              full;
        logic              empty;
        logic              abt;
    } ring_status_t;

    ring_status_t expected_status[$];

    // Shadow registers and ring state
    int ring_max;
    int keep_flag;
    int wr_idx;
    int rd_idx;
    int stored;
    int shown;
    int sum_ms;
    int slot_ms [QUEUE_DEPTH];

    initial mismatches = 0;

    function automatic int ring_size();
        int s;
        s = ring_max;
        if (s == 0)
            s = 1;
        if (s > QUEUE_DEPTH)
            s = QUEUE_DEPTH;
        return s;
    endfunction

    function automatic void clear_ring();
        ring_max  = 16;
        keep_flag = 0;
        wr_idx    = 0;
        rd_idx    = 0;
        stored    = 0;
        shown     = 0;
        sum_ms    = 0;
        foreach (slot_ms[i])
            slot_ms[i] = 0;
    endfunction

    // Applies one command to the shadow ring and returns the status it leaves behind.
    function automatic ring_status_t step_ring(input logic [1:0] cmd,
                                               input logic [DUR_W-1:0] dur,
                                               input logic abt);
        ring_status_t st;
        int size;
        int w;
        int r;
        int rem;
        int d;
        logic took;
        size = ring_size();
        w    = wr_idx % size;
        r    = rd_idx % size;
        took = 1'b0;
        rem  = (stored > shown) ? stored - shown : 0;
        case (cmd)
            CMD_PUSH:
                if (stored < size && !abt) begin
                    slot_ms[w] = int'(dur);
                    w = (w + 1) % size;
                    stored++;
                    sum_ms += int'(dur);
                    if (sum_ms > int'(SUM_MAX))
                        sum_ms = int'(SUM_MAX);
                    took = 1'b1;
                end
            CMD_NEXT:
                if (rem != 0) begin
                    if (keep_flag != 0 && shown == 0) begin
                        shown = 1;
                    end
                    else begin
                        d = slot_ms[r];
                        r = (r + 1) % size;
                        stored--;
                        sum_ms = (sum_ms > d) ? sum_ms - d : 0;
                    end
                    took = 1'b1;
                end
            CMD_QUERY:
                took = 1'b1;
            default:
                took = 1'b0;
        endcase
        wr_idx = w;
        rd_idx = r;
        rem    = (stored > shown) ? stored - shown : 0;

        st.acc     = took;
        st.wr_slot = SLOT_W'(w);
        st.show    = SLOT_W'((r + shown) % size);
        st.last    = SLOT_W'(r);
        st.nxt     = SLOT_W'((r + shown + 1) % size);
        st.rem     = CNT_W'(rem);
        st.total   = SUM_W'(sum_ms);
        st.full    = (stored >= size);
        st.empty   = (rem == 0);
        st.abt     = abt;
        return st;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        ring_status_t want;
        if (!rst_n) begin
            clear_ring();
            expected_status.delete();
            outstanding = 0;
        end
        else begin
            // result side first: a status never leaves in the cycle of its own transfer
            if (out_valid && out_ready) begin
                if (expected_status.size() == 0) begin
                    $error("result transfer with no status outstanding");
                    mismatches++;
                end
                else begin
                    want = expected_status.pop_front();
                    check_field("accepted",       32'(want.acc),     32'(accepted));
                    check_field("write_slot",     32'(want.wr_slot), 32'(write_slot));
                    check_field("show_slot",      32'(want.show),    32'(show_slot));
                    check_field("last_slot",      32'(want.last),    32'(last_slot));
                    check_field("next_slot",      32'(want.nxt),     32'(next_slot));
                    check_field("remaining",      32'(want.rem),     32'(remaining));
                    check_field("total_duration", 32'(want.total),   32'(total_duration));
                    check_field("full_res",       32'(want.full),    32'(full_res));
                    check_field("empty_res",      32'(want.empty),   32'(empty_res));
                    check_field("aborted",        32'(want.abt),     32'(aborted));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MAX_ENTRIES)
                    ring_max = int'(cfg_data);
                else if (cfg_index == CFG_HOLD_SHOWN)
                    keep_flag = int'(cfg_data[0]);
            end
            if (in_valid && in_ready)
                expected_status.push_back(step_ring(command, frame_dur, abort_request));
            outstanding = expected_status.size();
        end
    end

endmodule

FILE: tb/frame_ring_queue_keep_last_tb.sv
// Testbench top for the frame ring queue: stimulus, back-pressure and the final verdict.
`timescale 1ns / 1ps

module frame_ring_queue_keep_last_tb
    import frqkl_pkg::*;
;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1920;
    localparam int PHASE_ITEMS  = 160;

    // Command code the block must refuse, and a register index it must ignore
    localparam logic [1:0]           CMD_UNDEF = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Ring sizes for the first random phases: the extremes (0 reads as 1, above the
    // built depth reads as the depth) mixed with ordinary ones; later phases pick at random.
    localparam int SIZE_PLAN [8] = '{1, 16, 0, 31, 2, 17, 3, 9};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            command;
    logic [DUR_W-1:0]      frame_dur;
    logic                  abort_request;
    logic                  out_valid;
    logic                  out_ready;
    logic                  accepted;
    logic [SLOT_W-1:0]     write_slot;
    logic [SLOT_W-1:0]     show_slot;
    logic [SLOT_W-1:0]     last_slot;
    logic [SLOT_W-1:0]     next_slot;
    logic [CNT_W-1:0]      remaining;
    logic [SUM_W-1:0]      total_duration;
    logic                  full_res;
    logic                  empty_res;
    logic                  aborted;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;

    // Set for one whole phase: neither side idles at random while it is high
    bit steady;

    frame_ring_queue_keep_last #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (.*);

    ring_status_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        #(64'd5_000_000);
        $display("[frame_ring_queue_keep_last] ERROR");
        $finish;
    end

    // Offers one item and holds it until the transfer. Afterwards the sender may go
    // quiet at random; otherwise valid stays high into the next item.
    task automatic offer_item(input logic [1:0] cmd, input logic [DUR_W-1:0] dur,
                              input logic abt);
        in_valid      <= 1'b1;
        command       <= cmd;
        frame_dur     <= dur;
        abort_request <= abt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (!steady && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // Leaves cfg_valid high so that back-to-back writes need only one assignment per edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Both registers in one burst; the hold-shown write carries random upper bits,
    // which must be ignored
    task automatic program_ring(input logic [CFG_DATA_W-1:0] size_val, input logic keep);
        write_reg(CFG_MAX_ENTRIES, size_val);
        write_reg(CFG_HOLD_SHOWN, {4'($urandom_range(0, 15)), keep});
        cfg_valid <= 1'b0;
    endtask

    // Stops offering and waits until every status has come back
    task automatic settle_ring();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Receiver: random single and short stalls, plus a long hold-off every so often
    // while the sender keeps offering, so the pipeline backs up and drops in_ready.
    initial
    begin
        int taken;
        int hold;
        int hold_at;
        out_ready = 1'b0;
        taken     = 0;
        hold      = 0;
        hold_at   = 300;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (taken >= hold_at) begin
                hold    = 60;
                hold_at += 700;
                out_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(99) < 12) begin
                hold = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int n;
        int i;
        int phase;
        int pick;
        int push_pct;
        logic [1:0] cmd;
        logic [DUR_W-1:0] dur;
        logic [CFG_DATA_W-1:0] size_val;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_QUERY;
        frame_dur     = '0;
        abort_request = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MAX_ENTRIES;
        cfg_data      = '0;
        steady        = 1'b0;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // Unknown register index first, then the reset values written explicitly.
        write_reg(CFG_SPARE, 5'($urandom_range(0, 31)));
        program_ring(5'd16, 1'b0);

        offer_item(CMD_NEXT, 16'h0000, 1'b0);   // next on an empty ring: refused
        offer_item(CMD_QUERY, 16'hFFFF, 1'b1);  // query under abort still succeeds
        offer_item(CMD_PUSH, 16'hFFFF, 1'b1);   // push under abort: refused

        // Fill every slot once at full size; no slot is left unwritten for later resizes.
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            case (i)
                0:       dur = 16'h0000;
                1:       dur = 16'hFFFF;
                2:       dur = 16'h5555;
                3:       dur = 16'hAAAA;
                default: dur = DUR_W'($urandom());
            endcase
            offer_item(CMD_PUSH, dur, 1'b0);
        end
        offer_item(CMD_PUSH, 16'h1234, 1'b0);   // ring full: refused
        offer_item(CMD_UNDEF, 16'hFFFF, 1'b0);  // undefined command: refused, no change
        offer_item(CMD_NEXT, 16'h0000, 1'b1);
        offer_item(CMD_NEXT, 16'h0000, 1'b0);

        // Shrink to one slot with frames still stored, keep-last on: first next only
        // marks the frame shown, the second retires it.
        settle_ring();
        program_ring(5'd0, 1'b1);
        offer_item(CMD_NEXT, 16'h0000, 1'b0);
        offer_item(CMD_NEXT, 16'h0000, 1'b0);
        offer_item(CMD_PUSH, 16'h00FF, 1'b0);   // still over the new size: refused

        // Size above the built depth; keep-last dropped while the shown flag is set
        settle_ring();
        program_ring(5'd31, 1'b0);
        offer_item(CMD_NEXT, 16'h0000, 1'b0);
        offer_item(CMD_NEXT, 16'h0000, 1'b0);

        // ---- random part ----
        // Phases change size and keep-last without draining the ring, so resizing in
        // use gets plenty of traffic. Each phase leans towards filling or emptying.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                phase = n / PHASE_ITEMS;
                settle_ring();
                steady = (phase == 4);
                if (phase < 8)
                    size_val = CFG_DATA_W'(SIZE_PLAN[phase]);
                else
                    size_val = CFG_DATA_W'($urandom_range(0, 31));
                program_ring(size_val, phase[0]);
                push_pct = $urandom_range(25, 75);
            end

            pick = $urandom_range(99);
            if (pick < push_pct)
                cmd = CMD_PUSH;
            else if (pick < 92)
                cmd = CMD_NEXT;
            else if (pick < 98)
                cmd = CMD_QUERY;
            else
                cmd = CMD_UNDEF;

            case ($urandom_range(7))
                0:       dur = '0;
                1:       dur = '1;
                2:       dur = DUR_W'($urandom_range(1, 50));
                default: dur = DUR_W'($urandom());
            endcase

            offer_item(cmd, dur, $urandom_range(99) < 8);
        end

        settle_ring();
        steady = 1'b0;
        // wait on to catch any stray result transfer
        repeat (8)
            @(posedge clk);

        if (mismatches == 0)
            $display("[frame_ring_queue_keep_last] OK");
        else
            $display("[frame_ring_queue_keep_last] ERROR");
        $finish;
    end

endmodule

FILE: frame_ring_queue_keep_last.f
rtl/frqkl_pkg.sv
rtl/frame_ring_queue_keep_last.sv
tb/ring_status_checker.sv
tb/frame_ring_queue_keep_last_tb.sv
